@@ hdl/fcb_pkg.sv @@
// Shared types and constants for the freezer cartridge bank controller.
package fcb_pkg;

	// Memory geometry: four 8K ROM pages and one 8K RAM page
	localparam int unsigned ROM_AW     = 15;
	localparam int unsigned RAM_AW     = 13;
	localparam int unsigned PAGE_AW    = 13;
	localparam int unsigned WIN_AW     = 8;
	localparam int unsigned BANK_W     = 2;
	localparam int unsigned RAM_DEPTH  = 8192;

	// The I/O window shows the last 256 bytes of a page (offset 0x1f00)
	localparam logic [PAGE_AW-WIN_AW-1:0] WIN_PAGE_HI = 5'h1f;

	// Queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	// Operation codes
	localparam logic [3:0] OP_CTRL_WR  = 4'd0;
	localparam logic [3:0] OP_CTRL_RD  = 4'd1;
	localparam logic [3:0] OP_WIN_RD   = 4'd2;
	localparam logic [3:0] OP_WIN_WR   = 4'd3;
	localparam logic [3:0] OP_ROML_RD  = 4'd4;
	localparam logic [3:0] OP_ROML_WR  = 4'd5;
	localparam logic [3:0] OP_FREEZE   = 4'd6;
	localparam logic [3:0] OP_COLD     = 4'd7;
	localparam logic [3:0] OP_RESET    = 4'd8;
	localparam logic [3:0] OP_ROM_LOAD = 4'd9;

	// Control byte bit positions
	localparam int unsigned CTRL_IO_OFF_BIT  = 2;
	localparam int unsigned CTRL_RAM_BIT     = 5;
	localparam int unsigned CTRL_RELEASE_BIT = 6;

	// Source of the byte returned for a transfer
	typedef enum logic [1:0] {
		RD_NONE,
		RD_IMM,
		RD_RAM,
		RD_ROM
	} rd_kind_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [14:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic [1:0] exrom_game_lines;
		logic       ram_mapped;
		logic       freeze_release;
		logic       window_enabled;
	} rsp_t;

	// Mapping state seen after an operation
	typedef struct packed {
		logic [1:0] lines;
		logic       ram_mapped;
		logic       freeze_release;
		logic       window_enabled;
	} status_t;

	// Classified command handed from front to back
	typedef struct packed {
		rd_kind_t          kind;
		logic              ram_we;
		logic              rom_we;
		logic [ROM_AW-1:0] mem_addr;
		logic [7:0]        data;
		status_t           status;
	} cmd_t;

endpackage

@@ hdl/freeze_cart_bank_controller.sv @@
// Top level of the freezer cartridge bank controller.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_ready | fcb_pkg::req_t (op, address, write_data)
//   rsp     | out       | rsp_valid/rsp_ready | fcb_pkg::rsp_t (read data, mapping state)
//
// While neither side stalls, one request per cycle is accepted and one response
// per cycle delivered. Each request passes through the command queue and then the
// registered memory read of the back end.
// After reset the back end sweeps cartridge RAM to zero, one byte a cycle, over
// all 8192 bytes; req_ready is low for that time.
// A stalled response holds in the result stage while the four-entry queue keeps
// taking requests; once clearing is done, req_ready drops only when the queue is full.
module freeze_cart_bank_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fcb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fcb_pkg::rsp_t rsp
);
	import fcb_pkg::*;

	cmd_t front_cmd;
	cmd_t head;
	logic head_valid;
	logic full;
	logic push;
	logic pop;
	logic busy;

	// Accept while the queue has room and RAM clearing is done
	assign req_ready = !full && !busy;
	assign push      = req_valid && req_ready;

	fcb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.req    (req),
		.cmd    (front_cmd)
	);

	fcb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	fcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.busy       (busy),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

@@ hdl/fcb_front.sv @@
// Front end: decodes bus operations, owns the banking registers, builds commands.
module fcb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcb_pkg::req_t req,
	output fcb_pkg::cmd_t cmd
);
	import fcb_pkg::*;

	logic [7:0]        control_byte_q;
	logic              io_active_q;
	logic              ram_select_q;
	logic [BANK_W-1:0] bank_select_q;
	logic [1:0]        line_state_q;

	logic [7:0]        control_byte_d;
	logic              io_active_d;
	logic              ram_select_d;
	logic [BANK_W-1:0] bank_select_d;
	logic [1:0]        line_state_d;
	logic              release_d;

	logic [PAGE_AW-1:0] win_off;
	logic [PAGE_AW-1:0] roml_off;

	assign win_off  = {WIN_PAGE_HI, req.address[WIN_AW-1:0]};
	assign roml_off = req.address[PAGE_AW-1:0];

	// Decode the operation into next mapping state and a memory command
	always_comb begin
		control_byte_d = control_byte_q;
		io_active_d    = io_active_q;
		ram_select_d   = ram_select_q;
		bank_select_d  = bank_select_q;
		line_state_d   = line_state_q;
		release_d      = 1'b0;
		cmd.kind       = RD_NONE;
		cmd.ram_we     = 1'b0;
		cmd.rom_we     = 1'b0;
		cmd.mem_addr   = '0;
		cmd.data       = req.write_data;

		unique case (req.op)
			OP_CTRL_WR: begin
				if (io_active_q) begin
					control_byte_d = req.write_data;
					line_state_d   = req.write_data[1:0];
					bank_select_d  = req.write_data[4:3];
					ram_select_d   = req.write_data[CTRL_RAM_BIT];
					release_d      = req.write_data[CTRL_RELEASE_BIT];
					if (req.write_data[CTRL_IO_OFF_BIT]) begin
						io_active_d = 1'b0;
					end
				end
			end
			OP_CTRL_RD: begin
				cmd.kind = RD_IMM;
				cmd.data = control_byte_q;
			end
			OP_WIN_RD: begin
				if (io_active_q) begin
					if (ram_select_q) begin
						cmd.kind     = RD_RAM;
						cmd.mem_addr = {{BANK_W{1'b0}}, win_off};
					end else begin
						cmd.kind     = RD_ROM;
						cmd.mem_addr = {bank_select_q, win_off};
					end
				end
			end
			OP_WIN_WR: begin
				if (io_active_q && ram_select_q) begin
					cmd.ram_we   = 1'b1;
					cmd.mem_addr = {{BANK_W{1'b0}}, win_off};
				end
			end
			OP_ROML_RD: begin
				if (ram_select_q) begin
					cmd.kind     = RD_RAM;
					cmd.mem_addr = {{BANK_W{1'b0}}, roml_off};
				end else begin
					cmd.kind     = RD_ROM;
					cmd.mem_addr = {bank_select_q, roml_off};
				end
			end
			OP_ROML_WR: begin
				if (ram_select_q) begin
					cmd.ram_we   = 1'b1;
					cmd.mem_addr = {{BANK_W{1'b0}}, roml_off};
				end
			end
			OP_FREEZE: begin
				io_active_d   = 1'b1;
				line_state_d  = 2'd3;
				bank_select_d = '0;
				ram_select_d  = 1'b1;
			end
			OP_COLD: begin
				io_active_d   = 1'b1;
				line_state_d  = 2'd0;
				bank_select_d = '0;
				ram_select_d  = 1'b0;
			end
			OP_RESET: begin
				io_active_d = 1'b1;
			end
			OP_ROM_LOAD: begin
				cmd.rom_we   = 1'b1;
				cmd.mem_addr = req.address;
			end
			default: begin
			end
		endcase

		cmd.status.lines          = line_state_d;
		cmd.status.ram_mapped     = ram_select_d;
		cmd.status.freeze_release = release_d;
		cmd.status.window_enabled = io_active_d;
	end

	// Advance the banking registers on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_byte_q <= '0;
			io_active_q    <= 1'b1;
			ram_select_q   <= 1'b0;
			bank_select_q  <= '0;
			line_state_q   <= '0;
		end else if (push) begin
			control_byte_q <= control_byte_d;
			io_active_q    <= io_active_d;
			ram_select_q   <= ram_select_d;
			bank_select_q  <= bank_select_d;
			line_state_q   <= line_state_d;
		end
	end

endmodule

@@ hdl/fcb_queue.sv @@
// Short command queue decoupling the decode front from the memory back end.
module fcb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcb_pkg::cmd_t push_cmd,
	input  logic          pop,
	output fcb_pkg::cmd_t head,
	output logic          head_valid,
	output logic          full
);
	import fcb_pkg::*;

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == Q_CW'(Q_DEPTH));

	// Store entries; payload needs no reset
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/fcb_back.sv @@
// Back end: ROM and RAM arrays, RAM clearing pass and the result register.
module fcb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fcb_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          busy,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fcb_pkg::rsp_t rsp
);
	import fcb_pkg::*;

	logic [7:0] rom_mem_q [2**ROM_AW];
	logic [7:0] ram_mem_q [RAM_DEPTH];

	logic              clear_busy_q;
	logic [RAM_AW-1:0] clear_cnt_q;

	logic              valid_s2;
	rd_kind_t          kind_s2;
	logic [7:0]        imm_s2;
	status_t           status_s2;
	logic [7:0]        ram_rdata_s2;
	logic [7:0]        rom_rdata_s2;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic              rom_we;
	logic              rom_re;

	// Take the queue head when clearing is done and the result slot is free or being drained
	assign pop  = head_valid && !clear_busy_q && (!valid_s2 || rsp_ready);
	assign busy = clear_busy_q;

	assign ram_we    = clear_busy_q || (pop && head.ram_we);
	assign ram_waddr = clear_busy_q ? clear_cnt_q : head.mem_addr[RAM_AW-1:0];
	assign ram_wdata = clear_busy_q ? 8'h00 : head.data;
	assign ram_re    = pop && (head.kind == RD_RAM);
	assign rom_we    = pop && head.rom_we;
	assign rom_re    = pop && (head.kind == RD_ROM);

	// Sweep RAM to zero after reset, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_cnt_q  <= '0;
		end else if (clear_busy_q) begin
			clear_cnt_q <= clear_cnt_q + 1'b1;
			if (clear_cnt_q == {RAM_AW{1'b1}}) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	// RAM port: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_mem_q[ram_waddr] <= ram_wdata;
		end
		if (ram_re) begin
			ram_rdata_s2 <= ram_mem_q[head.mem_addr[RAM_AW-1:0]];
		end
	end

	// ROM port: load writes or registered reads
	always_ff @(posedge clk) begin
		if (rom_we) begin
			rom_mem_q[head.mem_addr] <= head.data;
		end
		if (rom_re) begin
			rom_rdata_s2 <= rom_mem_q[head.mem_addr];
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s2   <= head.kind;
			imm_s2    <= head.data;
			status_s2 <= head.status;
		end
	end

	// Select the returned byte
	always_comb begin
		unique case (kind_s2)
			RD_NONE: rsp.read_data = 8'h00;
			RD_IMM:  rsp.read_data = imm_s2;
			RD_RAM:  rsp.read_data = ram_rdata_s2;
			RD_ROM:  rsp.read_data = rom_rdata_s2;
			default: rsp.read_data = 8'h00;
		endcase
	end

	assign rsp.read_valid       = (kind_s2 != RD_NONE);
	assign rsp.exrom_game_lines = status_s2.lines;
	assign rsp.ram_mapped       = status_s2.ram_mapped;
	assign rsp.freeze_release   = status_s2.freeze_release;
	assign rsp.window_enabled   = status_s2.window_enabled;
	assign rsp_valid            = valid_s2;

	// No command may reach the memories while the clearing pass runs
	assert property (@(posedge clk) disable iff (!arst_n) clear_busy_q |-> !head_valid)
		else $error("command queued during RAM clear");

	// A stalled result keeps its memory read data
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_ready) |=> ($stable(ram_rdata_s2) && $stable(rom_rdata_s2)))
		else $error("read data changed while result stalled");

	// The clearing pass ends only after the last RAM byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_busy_q) |-> ($past(clear_cnt_q) == {RAM_AW{1'b1}}))
		else $error("RAM clear ended early");

endmodule
